// File: rtl/core/fpd_pkg.sv
package fpd_pkg;

  typedef enum logic [2:0] {
    PH_UNKNOWN  = 3'd0,
    PH_GROUND   = 3'd1,
    PH_DEPART   = 3'd2,
    PH_APPROACH = 3'd3,
    PH_FLYING   = 3'd4,
    PH_FAR      = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    SIT_GROUND = 2'd0,
    SIT_LOW    = 2'd1,
    SIT_FLY    = 2'd2
  } sit_t;

  typedef enum logic [2:0] {
    REG_IS_MOTORGLIDER   = 3'd0,
    REG_MAX_SPEED        = 3'd1,
    REG_MAX_SPEED_CHANGE = 3'd2,
    REG_MAX_ALT_CHANGE   = 3'd3,
    REG_KEEPALIVE_TICKS  = 3'd4,
    REG_LANDING_TICKS    = 3'd5
  } reg_idx_t;

  localparam int ALT_W   = 16;
  localparam int SPD_W   = 10;
  localparam int LIM_W   = 9;
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_I_W = 3;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 8;

  localparam logic [LIM_W-1:0] MAX_SPEED_RST        = 9'd111;
  localparam logic [LIM_W-1:0] MAX_SPEED_CHANGE_RST = 9'd27;
  localparam logic [ALT_W-1:0] MAX_ALT_CHANGE_RST   = 16'd100;
  localparam logic [CNT_W-1:0] KEEPALIVE_TICKS_RST  = 16'd30;
  localparam logic [CNT_W-1:0] LANDING_TICKS_RST    = 16'd300;

  localparam logic signed [SPD_W-1:0] SPD_GROUND = 10'sd2;
  localparam logic signed [SPD_W-1:0] SPD_SLOW   = 10'sd10;
  localparam logic signed [SPD_W-1:0] SPD_LOW    = 10'sd40;
  localparam logic signed [ALT_W-1:0] ALT_LOW    = 16'sd40;

endpackage

// File: rtl/core/flight_phase_detector.sv
// Flight phase tracker for one nearby aircraft. Each request on the input
// stream is either a traffic sample (tuser low) or a 100 ms time tick (tuser
// high), and each produces exactly one result carrying the phase after the
// request together with the plausible, departure, landing, touch-and-go and
// remove flags. The whole decision for a request is a few comparisons ahead
// of the state and result registers, so one request is taken every cycle
// while the result register is empty or being read. The configuration
// registers should only be written while no result is pending.
module flight_phase_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fpd_pkg::CFG_I_W-1:0]   cfg_index,
  input  logic [fpd_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // rel_altitude[15:0], ground_speed[25:16], zero fill
  input  logic [fpd_pkg::IN_W-1:0]      in_tdata,
  // opcode
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // flight_state[2:0], plausible[3], departure[4], landing[5],
  // touch_and_go[6], remove[7]
  output logic [fpd_pkg::OUT_W-1:0]     out_tdata
);
  import fpd_pkg::*;

  logic             is_mg_r;
  logic [LIM_W-1:0] max_speed_r;
  logic [LIM_W-1:0] max_speed_change_r;
  logic [ALT_W-1:0] max_alt_change_r;
  logic [CNT_W-1:0] keepalive_ticks_r;
  logic [CNT_W-1:0] landing_ticks_r;

  phase_t                  phase_r, phase_nxt, ka_phase;
  logic signed [ALT_W-1:0] prev_alt_r;
  logic signed [SPD_W-1:0] prev_spd_r;
  logic [CNT_W-1:0]        ka_cnt_r, ka_cnt_nxt;
  logic                    ka_act_r, ka_act_nxt;
  logic [CNT_W-1:0]        land_cnt_r, land_cnt_nxt;
  logic                    land_act_r, land_act_nxt;

  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;

  logic                    accept;
  logic                    is_tick;
  logic signed [ALT_W-1:0] alt;
  logic signed [SPD_W-1:0] spd;
  logic signed [ALT_W:0]   da;
  logic signed [SPD_W:0]   ds;
  logic [ALT_W:0]          da_abs;
  logic [SPD_W:0]          ds_abs;
  logic                    plaus;
  sit_t                    sit;
  logic                    ka_expire;
  logic                    land_expire;
  logic                    touchdown;
  logic                    dep, land, tag, rem;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign is_tick   = in_tuser;
  assign alt       = in_tdata[ALT_W-1:0];
  assign spd       = in_tdata[ALT_W+SPD_W-1:ALT_W];

  assign da     = {alt[ALT_W-1], alt} - {prev_alt_r[ALT_W-1], prev_alt_r};
  assign ds     = {spd[SPD_W-1], spd} - {prev_spd_r[SPD_W-1], prev_spd_r};
  assign da_abs = da[ALT_W] ? (~da + 1'b1) : da;
  assign ds_abs = ds[SPD_W] ? (~ds + 1'b1) : ds;

  assign plaus = !spd[SPD_W-1] && (spd[LIM_W-1:0] <= max_speed_r) &&
                 (da_abs <= {1'b0, max_alt_change_r}) &&
                 (ds_abs <= {2'b00, max_speed_change_r});

  always_comb begin
    if (spd < SPD_GROUND) begin
      sit = SIT_GROUND;
    end else if (spd < SPD_SLOW) begin
      sit = (alt < ALT_LOW) ? SIT_GROUND : SIT_FLY;
    end else if (spd < SPD_LOW) begin
      sit = (alt < ALT_LOW) ? SIT_LOW : SIT_FLY;
    end else begin
      sit = SIT_FLY;
    end
  end

  assign ka_expire   = is_tick && ka_act_r && (ka_cnt_r <= CNT_W'(1));
  assign land_expire = is_tick && land_act_r && (land_cnt_r <= CNT_W'(1));
  assign touchdown   = !is_tick && plaus && (sit == SIT_GROUND) &&
                       ((phase_r == PH_APPROACH) || (phase_r == PH_FLYING) ||
                        (phase_r == PH_FAR));

  // Next phase and countdowns.
  always_comb begin
    ka_phase     = phase_r;
    phase_nxt    = phase_r;
    ka_cnt_nxt   = ka_cnt_r;
    ka_act_nxt   = ka_act_r;
    land_cnt_nxt = land_cnt_r;
    land_act_nxt = land_act_r;
    if (is_tick) begin
      if (ka_expire) begin
        ka_cnt_nxt = '0;
        ka_act_nxt = 1'b0;
        case (phase_r)
          PH_APPROACH: ka_phase = PH_GROUND;
          PH_FLYING:   ka_phase = PH_FAR;
          default:     ka_phase = phase_r;
        endcase
      end else if (ka_act_r) begin
        ka_cnt_nxt = ka_cnt_r - 1'b1;
      end
      if (land_expire) begin
        land_cnt_nxt = '0;
        land_act_nxt = 1'b0;
      end else if (land_act_r) begin
        land_cnt_nxt = land_cnt_r - 1'b1;
      end
      phase_nxt = ka_phase;
    end else begin
      ka_cnt_nxt = keepalive_ticks_r;
      ka_act_nxt = 1'b1;
      if (plaus) begin
        case (phase_r)
          PH_GROUND: begin
            if (sit != SIT_GROUND) begin
              phase_nxt    = (sit == SIT_FLY) ? PH_FLYING : PH_DEPART;
              land_act_nxt = 1'b0;
            end
          end
          PH_APPROACH: begin
            if (sit == SIT_GROUND) phase_nxt = PH_GROUND;
            else if (sit == SIT_FLY) phase_nxt = PH_FLYING;
          end
          PH_FLYING: begin
            if (sit == SIT_GROUND) phase_nxt = PH_GROUND;
            else if (sit == SIT_LOW) phase_nxt = PH_APPROACH;
          end
          PH_FAR: begin
            if (sit == SIT_GROUND) phase_nxt = PH_GROUND;
            else if (sit == SIT_LOW) phase_nxt = PH_APPROACH;
            else phase_nxt = PH_FLYING;
          end
          PH_DEPART: begin
            if (sit == SIT_GROUND) phase_nxt = PH_GROUND;
            else if (sit == SIT_FLY) phase_nxt = PH_FLYING;
          end
          default: begin
            if (sit == SIT_GROUND) phase_nxt = PH_GROUND;
            else if (sit == SIT_FLY) phase_nxt = PH_FLYING;
            else phase_nxt = PH_APPROACH;
          end
        endcase
        if (touchdown && is_mg_r) begin
          land_cnt_nxt = landing_ticks_r;
          land_act_nxt = 1'b1;
        end
      end
    end
  end

  // Event flags.
  always_comb begin
    dep  = 1'b0;
    land = 1'b0;
    tag  = 1'b0;
    rem  = 1'b0;
    if (is_tick) begin
      rem  = ka_expire;
      land = (ka_expire && (phase_r == PH_APPROACH)) ||
             (land_expire && (ka_phase == PH_GROUND));
    end else if (plaus) begin
      case (phase_r)
        PH_GROUND: begin
          if (sit != SIT_GROUND) begin
            dep = !land_act_r;
            tag = land_act_r && is_mg_r;
          end
        end
        PH_APPROACH: begin
          tag  = (sit == SIT_FLY) && is_mg_r;
          land = touchdown && !is_mg_r;
        end
        PH_DEPART: land = (sit == SIT_GROUND);
        default:   land = touchdown && !is_mg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_mg_r            <= 1'b0;
      max_speed_r        <= MAX_SPEED_RST;
      max_speed_change_r <= MAX_SPEED_CHANGE_RST;
      max_alt_change_r   <= MAX_ALT_CHANGE_RST;
      keepalive_ticks_r  <= KEEPALIVE_TICKS_RST;
      landing_ticks_r    <= LANDING_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IS_MOTORGLIDER:   is_mg_r            <= cfg_data[0];
        REG_MAX_SPEED:        max_speed_r        <= cfg_data[LIM_W-1:0];
        REG_MAX_SPEED_CHANGE: max_speed_change_r <= cfg_data[LIM_W-1:0];
        REG_MAX_ALT_CHANGE:   max_alt_change_r   <= cfg_data[ALT_W-1:0];
        REG_KEEPALIVE_TICKS:  keepalive_ticks_r  <= cfg_data[CNT_W-1:0];
        REG_LANDING_TICKS:    landing_ticks_r    <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_UNKNOWN;
      prev_alt_r <= '0;
      prev_spd_r <= '0;
      ka_cnt_r   <= KEEPALIVE_TICKS_RST;
      ka_act_r   <= 1'b1;
      land_cnt_r <= '0;
      land_act_r <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      ka_cnt_r   <= ka_cnt_nxt;
      ka_act_r   <= ka_act_nxt;
      land_cnt_r <= land_cnt_nxt;
      land_act_r <= land_act_nxt;
      if (!is_tick) begin
        prev_alt_r <= alt;
        prev_spd_r <= spd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {rem, tag, land, dep, plaus && !is_tick, phase_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fpd_pkg::*;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;
  localparam int   N_SETS    = 12;
  localparam int   SET_ITEMS = 161;
  localparam int   LIMIT     = 1_000_000;

  typedef struct packed {
    logic   rem;
    logic   tag;
    logic   land;
    logic   dep;
    logic   plaus;
    phase_t st;
  } result_t;

  typedef struct packed {
    logic        wr;
    reg_idx_t    idx;
    logic [15:0] val;
    logic        op;
    logic [15:0] alt;
    logic [9:0]  spd;
    logic        chk;
    logic [7:0]  want;
  } row_t;

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [CFG_I_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]   cfg_data   = '0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata   = '0;
  logic               in_tuser   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_W-1:0]   out_tdata;

  // Shadow copy of the configuration registers.
  bit                 glider    = 1'b0;
  logic [LIM_W-1:0]   lim_spd   = MAX_SPEED_RST;
  logic [LIM_W-1:0]   lim_dspd  = MAX_SPEED_CHANGE_RST;
  logic [ALT_W-1:0]   lim_dalt  = MAX_ALT_CHANGE_RST;
  logic [CNT_W-1:0]   ka_len    = KEEPALIVE_TICKS_RST;
  logic [CNT_W-1:0]   ld_len    = LANDING_TICKS_RST;

  // Tracker state as the block should hold it.
  phase_t             ph        = PH_UNKNOWN;
  int                 prev_alt  = 0;
  int                 prev_spd  = 0;
  logic [CNT_W-1:0]   ka_cnt    = KEEPALIVE_TICKS_RST;
  bit                 ka_on     = 1'b1;
  logic [CNT_W-1:0]   ld_cnt    = '0;
  bit                 ld_on     = 1'b0;

  result_t            phases_due[$];
  int                 mismatches = 0;
  int                 cycles     = 0;
  bit                 src_calm   = 1'b0;
  bit                 sink_calm  = 1'b0;
  row_t               script [0:27];

  flight_phase_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int stall_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 2);
    if (roll < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  function automatic int toward(int cur, int tgt, int stp);
    int d;
    d = tgt - cur;
    if (d > stp) d = stp;
    if (d < -stp) d = -stp;
    return cur + d;
  endfunction

  function automatic sit_t situation(int alt, int spd);
    if (spd < 2) return SIT_GROUND;
    if (spd < 10) return (alt < 40) ? SIT_GROUND : SIT_FLY;
    if (spd < 40) return (alt < 40) ? SIT_LOW : SIT_FLY;
    return SIT_FLY;
  endfunction

  // A touchdown is settled at once, or deferred by the landing countdown for a
  // motorglider.
  task automatic touchdown(inout result_t r);
    ph = PH_GROUND;
    if (glider) begin
      ld_cnt = ld_len;
      ld_on  = 1'b1;
    end else begin
      r.land = 1'b1;
    end
  endtask

  task automatic advance_tracker(input logic op, input logic [15:0] alt_raw,
                                 input logic [9:0] spd_raw, output result_t r);
    int   alt;
    int   spd;
    int   dalt;
    int   dspd;
    sit_t s;
    alt = $signed(alt_raw);
    spd = $signed(spd_raw);
    r = '0;
    if (op == OP_SAMPLE) begin
      dalt = alt - prev_alt;
      dspd = spd - prev_spd;
      if (dalt < 0) dalt = -dalt;
      if (dspd < 0) dspd = -dspd;
      ka_cnt   = ka_len;
      ka_on    = 1'b1;
      prev_alt = alt;
      prev_spd = spd;
      r.plaus = (spd >= 0) && (spd <= int'(lim_spd)) && (dalt <= int'(lim_dalt)) &&
                (dspd <= int'(lim_dspd));
      if (r.plaus) begin
        s = situation(alt, spd);
        case (ph)
          PH_GROUND: begin
            if (s != SIT_GROUND) begin
              ph = (s == SIT_FLY) ? PH_FLYING : PH_DEPART;
              if (ld_on) begin
                ld_on = 1'b0;
                if (glider) r.tag = 1'b1;
              end else begin
                r.dep = 1'b1;
              end
            end
          end
          PH_APPROACH: begin
            if (s == SIT_GROUND) begin
              touchdown(r);
            end else if (s == SIT_FLY) begin
              ph = PH_FLYING;
              if (glider) r.tag = 1'b1;
            end
          end
          PH_FLYING: begin
            if (s == SIT_GROUND) touchdown(r);
            else if (s == SIT_LOW) ph = PH_APPROACH;
          end
          PH_FAR: begin
            if (s == SIT_GROUND) touchdown(r);
            else if (s == SIT_LOW) ph = PH_APPROACH;
            else ph = PH_FLYING;
          end
          PH_DEPART: begin
            if (s == SIT_GROUND) begin
              ph     = PH_GROUND;
              r.land = 1'b1;
            end else if (s == SIT_FLY) begin
              ph = PH_FLYING;
            end
          end
          default: begin
            if (s == SIT_GROUND) ph = PH_GROUND;
            else if (s == SIT_FLY) ph = PH_FLYING;
            else ph = PH_APPROACH;
          end
        endcase
      end
    end else begin
      if (ka_on) begin
        if (ka_cnt <= 16'd1) begin
          ka_cnt = '0;
          ka_on  = 1'b0;
          if (ph == PH_APPROACH) begin
            ph     = PH_GROUND;
            r.land = 1'b1;
          end else if (ph == PH_FLYING) begin
            ph = PH_FAR;
          end
          r.rem = 1'b1;
        end else begin
          ka_cnt = ka_cnt - 16'd1;
        end
      end
      if (ld_on) begin
        if (ld_cnt <= 16'd1) begin
          ld_cnt = '0;
          ld_on  = 1'b0;
          if (ph == PH_GROUND) r.land = 1'b1;
        end else begin
          ld_cnt = ld_cnt - 16'd1;
        end
      end
    end
    r.st = ph;
  endtask

  task automatic offer(input logic op, input logic [15:0] alt, input logic [9:0] spd,
                       input logic chk, input logic [7:0] want);
    result_t r;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'b0, spd, alt};
    do @(posedge clk); while (!in_tready);
    advance_tracker(op, alt, spd, r);
    phases_due.push_back(chk ? result_t'(want) : r);
  endtask

  task automatic pause();
    int n;
    if (!src_calm && $urandom_range(0, 2) == 0) begin
      n = stall_len();
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (phases_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_reg(input reg_idx_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_IS_MOTORGLIDER:   glider   = val[0];
      REG_MAX_SPEED:        lim_spd  = val[LIM_W-1:0];
      REG_MAX_SPEED_CHANGE: lim_dspd = val[LIM_W-1:0];
      REG_MAX_ALT_CHANGE:   lim_dalt = val;
      REG_KEEPALIVE_TICKS:  ka_len   = val;
      REG_LANDING_TICKS:    ld_len   = val;
      default: ;
    endcase
  endtask

  task automatic configure(input int mg, input int ms, input int msc, input int mac,
                           input int ka, input int ld);
    drain();
    set_reg(REG_IS_MOTORGLIDER, 16'(mg));
    set_reg(REG_MAX_SPEED, 16'(ms));
    set_reg(REG_MAX_SPEED_CHANGE, 16'(msc));
    set_reg(REG_MAX_ALT_CHANGE, 16'(mac));
    set_reg(REG_KEEPALIVE_TICKS, 16'(ka));
    set_reg(REG_LANDING_TICKS, 16'(ld));
    cfg_we <= 1'b0;
  endtask

  task automatic flag(input string f, input int e, input int a);
    $display("%0t: %s expected %0d, got %0d", $time, f, e, a);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata);
      if (phases_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = phases_due.pop_front();
        if (got.st !== want.st) flag("flight_state", want.st, got.st);
        if (got.plaus !== want.plaus) flag("plausible", want.plaus, got.plaus);
        if (got.dep !== want.dep) flag("departure", want.dep, got.dep);
        if (got.land !== want.land) flag("landing", want.land, got.land);
        if (got.tag !== want.tag) flag("touch_and_go", want.tag, got.tag);
        if (got.rem !== want.rem) flag("remove", want.rem, got.rem);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[flight_phase_detector] ERROR");
      $finish;
    end
  end

  initial begin : sink
    int n;
    forever begin
      @(posedge clk);
      if (sink_calm || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
      end else begin
        n = stall_len();
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int roll;
    int burst_left;
    int g_alt;
    int g_spd;
    int tgt_alt;
    int tgt_spd;
    burst_left = 0;
    g_alt      = 0;
    g_spd      = 0;
    tgt_alt    = 0;
    tgt_spd    = 0;
    // Fields: write, index, value, opcode, altitude, speed, checked, result.
    script = '{
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_TICK,   16'd0,     10'd0,   1'b1, 8'h00},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_SAMPLE, 16'd0,     10'd0,   1'b1, 8'h09},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_SAMPLE, 16'd0,     10'h200, 1'b1, 8'h01},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_SAMPLE, 16'd0,     10'd511, 1'b1, 8'h01},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_SAMPLE, 16'd0,     10'd20,  1'b1, 8'h01},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_SAMPLE, 16'd10,    10'd20,  1'b0, 8'h00},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_SAMPLE, 16'd60,    10'd45,  1'b0, 8'h00},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_SAMPLE, 16'd30,    10'd25,  1'b0, 8'h00},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_SAMPLE, 16'd30,    10'd50,  1'b0, 8'h00},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_SAMPLE, 16'd20,    10'd30,  1'b0, 8'h00},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_SAMPLE, 16'd10,    10'd5,   1'b0, 8'h00},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_SAMPLE, 16'h7FFF,  10'd1,   1'b1, 8'h01},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_SAMPLE, 16'h8000,  10'd1,   1'b1, 8'h01},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_SAMPLE, 16'd0,     10'd1,   1'b1, 8'h01},
      '{1'b1, REG_KEEPALIVE_TICKS, 16'd1,     OP_SAMPLE, 16'd0,     10'd0,   1'b0, 8'h00},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_SAMPLE, 16'd50,    10'd5,   1'b0, 8'h00},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_TICK,   16'd0,     10'd0,   1'b0, 8'h00},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_SAMPLE, 16'd20,    10'd25,  1'b0, 8'h00},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_TICK,   16'd0,     10'd0,   1'b0, 8'h00},
      '{1'b1, REG_IS_MOTORGLIDER,  16'd1,     OP_SAMPLE, 16'd0,     10'd0,   1'b0, 8'h00},
      '{1'b1, REG_LANDING_TICKS,   16'd1,     OP_SAMPLE, 16'd0,     10'd0,   1'b0, 8'h00},
      '{1'b1, REG_KEEPALIVE_TICKS, 16'hFFFF,  OP_SAMPLE, 16'd0,     10'd0,   1'b0, 8'h00},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_SAMPLE, 16'd45,    10'd20,  1'b0, 8'h00},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_SAMPLE, 16'd10,    10'd1,   1'b0, 8'h00},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_TICK,   16'd0,     10'd0,   1'b0, 8'h00},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_SAMPLE, 16'd45,    10'd20,  1'b0, 8'h00},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_SAMPLE, 16'd10,    10'd1,   1'b0, 8'h00},
      '{1'b0, REG_IS_MOTORGLIDER,  16'd0,     OP_SAMPLE, 16'd10,    10'd20,  1'b0, 8'h00}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].wr) begin
        drain();
        set_reg(script[i].idx, script[i].val);
        cfg_we <= 1'b0;
      end else begin
        offer(script[i].op, script[i].alt, script[i].spd, script[i].chk, script[i].want);
        pause();
      end
    end

    for (int s = 0; s < N_SETS; s++) begin
      configure(s % 2,
                (s == 3) ? 0 : (s == 5) ? 511 : $urandom_range(60, 140),
                (s == 4) ? 0 : (s == 6) ? 511 : $urandom_range(15, 40),
                (s == 4) ? 0 : (s == 7) ? 65535 : $urandom_range(60, 200),
                (s == 8) ? 65535 : (s == 2) ? 1 : $urandom_range(1, 12),
                (s == 9) ? 65535 : (s == 2) ? 1 : $urandom_range(1, 15));
      src_calm  = (s % 4 == 3);
      sink_calm = (s % 4 == 2);
      for (int k = 0; k < SET_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (burst_left == 0 && roll < 4) burst_left = $urandom_range(2, 40);
        if (burst_left > 0 || roll < 22) begin
          if (burst_left > 0) burst_left--;
          offer(OP_TICK, 16'($urandom), 10'($urandom), 1'b0, 8'h00);
        end else if (roll < 32) begin
          offer(OP_SAMPLE, 16'($urandom), 10'($urandom), 1'b0, 8'h00);
        end else begin
          if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 2))
              0: begin
                tgt_spd = $urandom_range(0, 9);
                tgt_alt = int'($urandom_range(0, 59)) - 20;
              end
              1: begin
                tgt_spd = $urandom_range(10, 39);
                tgt_alt = int'($urandom_range(0, 59)) - 20;
              end
              default: begin
                tgt_spd = $urandom_range(10, 150);
                tgt_alt = $urandom_range(40, 2000);
              end
            endcase
          end
          g_spd = toward(g_spd, tgt_spd, $urandom_range(1, 20));
          g_alt = toward(g_alt, tgt_alt, $urandom_range(1, 90));
          offer(OP_SAMPLE, 16'(g_alt), 10'(g_spd), 1'b0, 8'h00);
        end
        if (k == SET_ITEMS / 2) drain();
        else pause();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[flight_phase_detector] OK");
    end else begin
      $display("[flight_phase_detector] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/fpd_pkg.sv
rtl/core/flight_phase_detector.sv
tb/tb_top.sv
